### src/hex_color_string_parser_assert.svh
// assertion macros used by the rtl
`ifndef HEX_COLOR_STRING_PARSER_ASSERT_SVH
`define HEX_COLOR_STRING_PARSER_ASSERT_SVH

// antecedent in this cycle implies consequent in the same cycle
`define HCP_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent in this cycle implies consequent in the next cycle
`define HCP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### src/hcp_pkg.sv
`default_nettype none
package hcp_pkg;

    localparam int unsigned NumCells = 8;
    localparam logic [7:0] HashChar = 8'h23;
    localparam logic [3:0] CountSat = 4'd9;
    localparam logic [3:0] CountStore = 4'd8;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_BAD_LEN   = 2'd2,
        ST_BAD_DIGIT = 2'd3
    } hcp_status_t;

    typedef struct packed {
        hcp_status_t status;
        logic [7:0]  alpha;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
    } hcp_result_t;

    // bit 4 set for a non-hex character
    function automatic logic [4:0] hex_decode(input logic [7:0] ch);
        logic [4:0] v;
        v = 5'd16;
        if (ch >= 8'h30 && ch <= 8'h39) begin
            v = {1'b0, ch[3:0]};
        end else if ((ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46)) begin
            v = {1'b0, ch[3:0] + 4'd9};
        end
        return v;
    endfunction

    // v * 17
    function automatic logic [7:0] short_code(input logic [3:0] v);
        return {v, v};
    endfunction

endpackage
`default_nettype wire

### src/hcp_cell.sv
`default_nettype none
module hcp_cell (
    input  wire logic       aclk,
    input  wire logic       shift_en,
    input  wire logic [3:0] nib_in,
    output logic [3:0]      nib_next,
    output logic [3:0]      nib_q
);

    logic [3:0] nib_reg;

    assign nib_next = shift_en ? nib_in : nib_reg;
    assign nib_q    = nib_reg;

    always_ff @(posedge aclk) begin
        nib_reg <= nib_next;
    end

endmodule
`default_nettype wire

### src/hcp_result_buf.sv
`default_nettype none
module hcp_result_buf
    import hcp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    input  wire hcp_result_t in_data,
    output logic             in_ready,
    output logic             out_valid,
    output hcp_result_t      out_data,
    input  wire logic        out_ready
);

    logic        out_valid_reg;
    logic        skid_valid_reg;
    hcp_result_t out_reg;
    hcp_result_t skid_reg;
    logic        pop;

    assign pop       = out_valid_reg & out_ready;
    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || pop) begin
            out_valid_reg  <= skid_valid_reg | in_valid;
            skid_valid_reg <= 1'b0;
        end else if (in_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || pop) begin
            out_reg <= skid_valid_reg ? skid_reg : in_data;
        end else if (in_valid) begin
            skid_reg <= in_data;
        end
    end

endmodule
`default_nettype wire

### src/hex_color_string_parser.sv
// a result is formed from the beat with s_tlast and registered in the output buffer that drives m_tvalid
// throughput: one beat per cycle while s_tready is high; a two-deep output buffer holds results while m_tready is low
// eight nibble cells form a shift chain, one stage per digit
// reset (aresetn low, synchronous) clears digit count, flags, mode and output buffer
// nibble cells are not reset; only cells written in the current string are read
`default_nettype none
`include "hex_color_string_parser_assert.svh"
module hex_color_string_parser
    import hcp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // character
    input  wire logic [0:0]  s_tuser,   // char_present
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // red, green, blue, alpha
    output logic [1:0]       m_tuser,   // status
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic        mode_reg;
    logic [3:0]  count_reg;
    logic [3:0]  count_next;
    logic        bad_reg;
    logic        bad_next;
    logic        start_reg;
    logic        accept;
    logic        present;
    logic        is_digit;
    logic [4:0]  dec;
    logic        shift_en;
    logic        empty;
    logic [3:0]  cell_q    [NumCells];
    logic [3:0]  cell_next [NumCells];
    logic [3:0]  cell_in   [NumCells];
    hcp_result_t res;
    hcp_result_t out_res;
    logic        res_valid;

    assign pready = 1'b1;
    assign prdata = (paddr == 3'd0) ? {31'd0, mode_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
        end else if (psel && penable && pwrite && pready && paddr == 3'd0) begin
            mode_reg <= pwdata[0];
        end
    end

    assign accept   = s_tvalid & s_tready;
    assign present  = s_tuser[0];
    assign dec      = hex_decode(s_tdata);
    assign is_digit = present && !(start_reg && s_tdata == HashChar);
    assign shift_en = accept && is_digit && count_reg < CountStore;
    assign empty    = !present && start_reg;

    assign count_next = (is_digit && count_reg < CountSat) ? count_reg + 4'd1 : count_reg;
    assign bad_next   = bad_reg | (is_digit & dec[4]);

    // digit chain, newest digit enters cell 0
    genvar gi;
    generate
        for (gi = 0; gi < NumCells; gi++) begin : g_cell
            if (gi == 0) begin : g_head
                assign cell_in[gi] = dec[4] ? 4'd0 : dec[3:0];
            end else begin : g_link
                assign cell_in[gi] = cell_q[gi-1];
            end
            hcp_cell u_cell (
                .aclk     (aclk),
                .shift_en (shift_en),
                .nib_in   (cell_in[gi]),
                .nib_next (cell_next[gi]),
                .nib_q    (cell_q[gi])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 4'd0;
            bad_reg   <= 1'b0;
            start_reg <= 1'b1;
        end else if (accept) begin
            if (s_tlast) begin
                count_reg <= 4'd0;
                bad_reg   <= 1'b0;
                start_reg <= 1'b1;
            end else begin
                count_reg <= count_next;
                bad_reg   <= bad_next;
                start_reg <= start_reg & !present;
            end
        end
    end

    assign res_valid = accept & s_tlast;

    always_comb begin
        res = '0;
        priority if (empty) begin
            res.status = ST_EMPTY;
        end else if (count_next != 4'd3 && count_next != 4'd4 &&
                     count_next != 4'd6 && count_next != 4'd8) begin
            res.status = ST_BAD_LEN;
        end else if (bad_next) begin
            res.status = ST_BAD_DIGIT;
        end else if (count_next == 4'd3) begin
            res.red   = short_code(cell_next[2]);
            res.green = short_code(cell_next[1]);
            res.blue  = short_code(cell_next[0]);
            res.alpha = 8'hFF;
        end else if (count_next == 4'd4) begin
            if (mode_reg) begin
                res.alpha = short_code(cell_next[3]);
                res.red   = short_code(cell_next[2]);
                res.green = short_code(cell_next[1]);
                res.blue  = short_code(cell_next[0]);
            end else begin
                res.red   = short_code(cell_next[3]);
                res.green = short_code(cell_next[2]);
                res.blue  = short_code(cell_next[1]);
                res.alpha = short_code(cell_next[0]);
            end
        end else if (count_next == 4'd6) begin
            res.red   = {cell_next[5], cell_next[4]};
            res.green = {cell_next[3], cell_next[2]};
            res.blue  = {cell_next[1], cell_next[0]};
            res.alpha = 8'hFF;
        end else begin
            if (mode_reg) begin
                res.alpha = {cell_next[7], cell_next[6]};
                res.red   = {cell_next[5], cell_next[4]};
                res.green = {cell_next[3], cell_next[2]};
                res.blue  = {cell_next[1], cell_next[0]};
            end else begin
                res.red   = {cell_next[7], cell_next[6]};
                res.green = {cell_next[5], cell_next[4]};
                res.blue  = {cell_next[3], cell_next[2]};
                res.alpha = {cell_next[1], cell_next[0]};
            end
        end
    end

    hcp_result_buf u_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_data   (res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_data  (out_res),
        .out_ready (m_tready)
    );

    assign m_tdata = {out_res.alpha, out_res.blue, out_res.green, out_res.red};
    assign m_tuser = out_res.status;

    `HCP_ASSERT_SAME(a_stall_only_when_full, aclk, aresetn, !s_tready, m_tvalid && !$past(m_tready))
    `HCP_ASSERT_NEXT(a_restart_after_last, aclk, aresetn, accept && s_tlast,
                     count_reg == 4'd0 && start_reg && !bad_reg)
    `HCP_ASSERT_SAME(a_count_saturates, aclk, aresetn, 1'b1, count_reg <= CountSat)
    `HCP_ASSERT_SAME(a_error_zero_channels, aclk, aresetn, m_tvalid && m_tuser != ST_OK,
                     m_tdata == 32'd0)

endmodule
`default_nettype wire

### tb/tb_hex_color_string_parser.sv
module tb_hex_color_string_parser;
    import hcp_pkg::*;

    localparam logic [2:0] ADDR_ALPHA_FIRST = 3'd0;
    localparam int BEAT_TARGET = 960;
    localparam int RANDOM_PHASES = 4;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AFTER = 40;
    localparam int NO_TAIL = -1;
    localparam int ABSENT_END = -2;

    typedef struct {
        string       txt;
        int          tail;
        bit          hole;
        bit          mode;
        bit          chk;
        hcp_result_t res;
    } color_case_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // character
    logic [0:0]  s_tuser;   // char_present
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // red, green, blue, alpha
    logic [1:0]  m_tuser;   // status
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // predictor state
    logic [3:0]  nib_cells [8];
    int unsigned digit_cnt;
    bit          bad_seen;
    bit          at_start;
    bit          alpha_first;

    hcp_result_t color_q [$];
    color_case_t cases [$];
    logic [7:0]  str_q [$];
    int unsigned errors;
    int unsigned results_seen;
    int unsigned beats_sent;
    bit          tx_calm;
    bit          rx_calm;
    bit          hold_done;

    hex_color_string_parser DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic logic [4:0] nibble_of(input logic [7:0] ch);
        if (ch >= 8'h30 && ch <= 8'h39) begin
            return 5'(ch - 8'h30);
        end
        if (ch >= 8'h41 && ch <= 8'h46) begin
            return 5'(ch - 8'h41 + 8'd10);
        end
        if (ch >= 8'h61 && ch <= 8'h66) begin
            return 5'(ch - 8'h61 + 8'd10);
        end
        return 5'd16;
    endfunction

    function automatic logic [7:0] short_byte(input int i);
        return 8'(nib_cells[i] * 8'd17);
    endfunction

    function automatic logic [7:0] long_byte(input int i);
        return {nib_cells[i], nib_cells[i + 1]};
    endfunction

    // one beat into the model of the parser; returns 1 when a color comes out
    function automatic bit parse_color(input logic [7:0] ch, input logic pres,
                                       input logic lst, output hcp_result_t res);
        logic [4:0] v;
        bit         empty;
        res = '0;
        if (pres) begin
            if (!(at_start && ch == HashChar)) begin
                v = nibble_of(ch);
                if (v[4]) begin
                    bad_seen = 1'b1;
                    v = 5'd0;
                end
                if (digit_cnt < 8) nib_cells[digit_cnt] = v[3:0];
                if (digit_cnt < 9) digit_cnt++;
            end
            empty = 1'b0;
            at_start = 1'b0;
        end else begin
            empty = at_start;
        end
        if (!lst) return 1'b0;
        if (empty) begin
            res.status = ST_EMPTY;
        end else if (digit_cnt != 3 && digit_cnt != 4 && digit_cnt != 6 && digit_cnt != 8) begin
            res.status = ST_BAD_LEN;
        end else if (bad_seen) begin
            res.status = ST_BAD_DIGIT;
        end else begin
            res.status = ST_OK;
            case (digit_cnt)
                3: begin
                    res.red = short_byte(0);
                    res.green = short_byte(1);
                    res.blue = short_byte(2);
                    res.alpha = 8'hff;
                end
                4: begin
                    if (alpha_first) begin
                        res.alpha = short_byte(0);
                        res.red = short_byte(1);
                        res.green = short_byte(2);
                        res.blue = short_byte(3);
                    end else begin
                        res.red = short_byte(0);
                        res.green = short_byte(1);
                        res.blue = short_byte(2);
                        res.alpha = short_byte(3);
                    end
                end
                6: begin
                    res.red = long_byte(0);
                    res.green = long_byte(2);
                    res.blue = long_byte(4);
                    res.alpha = 8'hff;
                end
                default: begin
                    if (alpha_first) begin
                        res.alpha = long_byte(0);
                        res.red = long_byte(2);
                        res.green = long_byte(4);
                        res.blue = long_byte(6);
                    end else begin
                        res.red = long_byte(0);
                        res.green = long_byte(2);
                        res.blue = long_byte(4);
                        res.alpha = long_byte(6);
                    end
                end
            endcase
        end
        digit_cnt = 0;
        bad_seen = 1'b0;
        at_start = 1'b1;
        return 1'b1;
    endfunction

    function automatic int idle_len(input bit calm);
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] hex_char();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10) return 8'(8'h30 + v);
        return 8'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + v - 10);
    endfunction

    function automatic logic [7:0] bad_char();
        logic [7:0] c;
        logic [4:0] v;
        if ($urandom_range(0, 3) == 0) return HashChar;
        do begin
            c = 8'($urandom_range(0, 255));
            v = nibble_of(c);
        end while (!v[4]);
        return c;
    endfunction

    function automatic int form_len();
        case ($urandom_range(0, 3))
            0: return 3;
            1: return 4;
            2: return 6;
            default: return 8;
        endcase
    endfunction

    task automatic push_beat(input logic [7:0] ch, input logic pres, input logic lst,
                             input bit chk, input hcp_result_t typed);
        hcp_result_t res;
        int          gap;
        s_tvalid <= 1'b1;
        s_tdata <= ch;
        s_tuser <= pres;
        s_tlast <= lst;
        do @(posedge aclk); while (!s_tready);
        if (parse_color(ch, pres, lst, res)) color_q.push_back(chk ? typed : res);
        if (pres || lst) beats_sent++;
        @(negedge aclk);
        gap = idle_len(tx_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            s_tdata <= 8'($urandom_range(0, 255));
            s_tuser <= 1'($urandom_range(0, 1));
            s_tlast <= 1'($urandom_range(0, 1));
            repeat (gap) @(negedge aclk);
        end
    endtask

    // hole_at: ignored beat (no character, not last) placed before that character
    task automatic send_string(input bit absent_end, input int hole_at, input bit chk,
                               input hcp_result_t typed);
        int n;
        n = str_q.size();
        if (n == 0) absent_end = 1'b1;
        for (int i = 0; i < n; i++) begin
            if (i == hole_at) push_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, typed);
            push_beat(str_q[i], 1'b1, !absent_end && i == n - 1, chk, typed);
        end
        if (absent_end) push_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1, chk, typed);
    endtask

    task automatic random_string();
        int kind;
        int len;
        int hole;
        bit absent_end;
        str_q = {};
        kind = $urandom_range(0, 99);
        if ($urandom_range(0, 1)) str_q.push_back(HashChar);
        if (kind < 60) begin
            len = form_len();
            repeat (len) str_q.push_back(hex_char());
        end else if (kind < 75) begin
            len = $urandom_range(0, 12);
            repeat (len) str_q.push_back(hex_char());
        end else if (kind < 87) begin
            len = form_len();
            repeat (len) str_q.push_back(hex_char());
            str_q[$urandom_range(0, str_q.size() - 1)] = bad_char();
        end else if (kind < 95) begin
            len = $urandom_range(1, 10);
            repeat (len) str_q.push_back(8'($urandom_range(0, 255)));
        end else begin
            str_q = {};
        end
        absent_end = str_q.size() == 0 || $urandom_range(0, 9) == 0;
        hole = $urandom_range(0, 7) == 0 ? $urandom_range(0, str_q.size()) : -1;
        send_string(absent_end, hole, 1'b0, '0);
    endtask

    task automatic write_mode(input bit m);
        s_tvalid <= 1'b0;
        wait (color_q.size() == 0);
        repeat (4) @(negedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ADDR_ALPHA_FIRST;
        pwdata <= {31'd0, m};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        alpha_first = m;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic add_case(input string txt, input int tail, input bit hole, input bit mode,
                            input bit chk, input hcp_status_t st, input logic [7:0] r,
                            input logic [7:0] g, input logic [7:0] b, input logic [7:0] a);
        color_case_t c;
        c.txt = txt;
        c.tail = tail;
        c.hole = hole;
        c.mode = mode;
        c.chk = chk;
        c.res.status = st;
        c.res.red = r;
        c.res.green = g;
        c.res.blue = b;
        c.res.alpha = a;
        cases.push_back(c);
    endtask

    task automatic check_field(input string what, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want) begin
            errors++;
            $display("%0t: %s expected %h actual %h", $time, what, want, got);
        end
    endtask

    always @(posedge aclk) begin
        hcp_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (color_q.size() == 0) begin
                errors++;
                $display("%0t: color expected none actual tdata %h tuser %0d",
                         $time, m_tdata, m_tuser);
            end else begin
                want = color_q.pop_front();
                check_field("red", m_tdata[7:0], want.red);
                check_field("green", m_tdata[15:8], want.green);
                check_field("blue", m_tdata[23:16], want.blue);
                check_field("alpha", m_tdata[31:24], want.alpha);
                check_field("status", {6'd0, m_tuser}, {6'd0, want.status});
            end
        end
    end

    // result side: random stalls, one long hold-off while beats keep coming
    initial begin
        int cyc;
        int stall;
        m_tready = 1'b0;
        cyc = 0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (cyc % 128 == 0) rx_calm = $urandom_range(0, 3) == 0;
            cyc++;
            if (!hold_done && results_seen >= HOLD_AFTER) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                m_tready <= 1'b1;
            end else begin
                stall = idle_len(rx_calm);
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(negedge aclk);
                end
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        color_case_t c;
        int          phase_end;
        int          n_str;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'd0;
        s_tuser = 1'b0;
        s_tlast = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = 3'd0;
        pwdata = 32'd0;
        digit_cnt = 0;
        bad_seen = 1'b0;
        at_start = 1'b1;
        alpha_first = 1'b0;
        errors = 0;
        results_seen = 0;
        beats_sent = 0;
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        hold_done = 1'b0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        add_case("", ABSENT_END, 0, 0, 1, ST_EMPTY, 0, 0, 0, 0);
        add_case("#", NO_TAIL, 0, 0, 1, ST_BAD_LEN, 0, 0, 0, 0);
        add_case("#", ABSENT_END, 0, 0, 1, ST_BAD_LEN, 0, 0, 0, 0);
        add_case("#fff", NO_TAIL, 0, 0, 1, ST_OK, 8'hff, 8'hff, 8'hff, 8'hff);
        add_case("000", NO_TAIL, 0, 0, 1, ST_OK, 0, 0, 0, 8'hff);
        add_case("#FFFFFFFF", NO_TAIL, 0, 0, 1, ST_OK, 8'hff, 8'hff, 8'hff, 8'hff);
        add_case("#00000000", NO_TAIL, 0, 0, 1, ST_OK, 0, 0, 0, 0);
        add_case("#1a2B3c", NO_TAIL, 0, 0, 0, ST_OK, 0, 0, 0, 0);
        add_case("#a4c", ABSENT_END, 1, 0, 0, ST_OK, 0, 0, 0, 0);
        add_case("#abcd", NO_TAIL, 0, 0, 0, ST_OK, 0, 0, 0, 0);
        add_case("#0123abcd", NO_TAIL, 0, 0, 0, ST_OK, 0, 0, 0, 0);
        add_case("#123456789", NO_TAIL, 0, 0, 1, ST_BAD_LEN, 0, 0, 0, 0);
        add_case("#12345678901234", NO_TAIL, 0, 0, 1, ST_BAD_LEN, 0, 0, 0, 0);
        add_case("12345", NO_TAIL, 0, 0, 1, ST_BAD_LEN, 0, 0, 0, 0);
        add_case("#1g", NO_TAIL, 0, 0, 1, ST_BAD_LEN, 0, 0, 0, 0);
        add_case("12g", NO_TAIL, 0, 0, 1, ST_BAD_DIGIT, 0, 0, 0, 0);
        add_case("#1#2", NO_TAIL, 0, 0, 1, ST_BAD_DIGIT, 0, 0, 0, 0);
        add_case("##12", NO_TAIL, 0, 0, 1, ST_BAD_DIGIT, 0, 0, 0, 0);
        add_case("#12", 255, 0, 0, 1, ST_BAD_DIGIT, 0, 0, 0, 0);
        add_case("#12", 0, 0, 0, 1, ST_BAD_DIGIT, 0, 0, 0, 0);
        add_case("#abcd", NO_TAIL, 0, 1, 0, ST_OK, 0, 0, 0, 0);
        add_case("#0123abcd", NO_TAIL, 0, 1, 0, ST_OK, 0, 0, 0, 0);
        add_case("fedcba98", NO_TAIL, 1, 1, 0, ST_OK, 0, 0, 0, 0);
        add_case("#9e7", NO_TAIL, 0, 1, 0, ST_OK, 0, 0, 0, 0);
        add_case("#FfFf", NO_TAIL, 0, 1, 1, ST_OK, 8'hff, 8'hff, 8'hff, 8'hff);

        foreach (cases[k]) begin
            c = cases[k];
            if (c.mode != alpha_first) write_mode(c.mode);
            str_q = {};
            for (int i = 0; i < c.txt.len(); i++) str_q.push_back(c.txt[i]);
            if (c.tail >= 0) str_q.push_back(8'(c.tail));
            send_string(c.tail == ABSENT_END, c.hole ? 1 : -1, c.chk, c.res);
        end

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_mode(p % 2 == 1);
            phase_end = beats_sent + BEAT_TARGET / RANDOM_PHASES;
            n_str = 0;
            while (beats_sent < phase_end) begin
                if (n_str % 20 == 0) tx_calm = $urandom_range(0, 3) == 0;
                n_str++;
                random_string();
            end
        end

        s_tvalid <= 1'b0;
        wait (color_q.size() == 0);
        repeat (10) @(negedge aclk);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
